// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the bitmap extent allocator modules.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define BEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define BEA_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BEA_ASSERT(label, clk, rst, prop, msg)
`define BEA_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/bea_pkg.sv =====
// Shared types and constants for the bitmap extent allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bea_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 9;
   localparam int WORD_W   = 64;
   localparam int LEN_W    = 16;
   localparam int STATUS_W = 2;
   localparam int START_W  = 15;

   typedef enum logic [CMD_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_ALLOC = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_ROOM   = 2'd1,
      ST_BAD_COUNT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      RES_ZERO   = 3'd0,
      RES_READ   = 3'd1,
      RES_BAD    = 3'd2,
      RES_NOROOM = 3'd3,
      RES_ALLOC  = 3'd4
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        write_word;
      logic        read_word;
      logic        scan_start;
      logic        scan_step;
      logic        clr_read;
      logic        clr_write;
      logic        set_res;
      res_sel_type res_sel;
      logic        load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             len_bad;
      logic             hit;
      logic             scan_end;
      logic             clr_last;
   } dp_status_type;

endpackage

// ===== rtl/bea_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds no reset and no initial contents.
module bea_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bea_datapath.sv =====
// Datapath of the bitmap extent allocator: request and result registers, the bitmap
// memory, the word-at-a-time run scanner and the run clearing logic.
// Depends on bea_pkg, bea_ram and assert_macros.svh.
`include "assert_macros.svh"
module bea_datapath import bea_pkg::*; #(
   parameter int NBITS = 32768
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       sts,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_word_index,
   input  logic [WORD_W-1:0]   req_word_data,
   input  logic [LEN_W-1:0]    req_run_length,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0]  rsp_start_block,
   output logic [WORD_W-1:0]   rsp_read_data
);

   localparam int NWORDS = (NBITS + 63) / 64;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int BW     = AW + 6;
   localparam int RW     = $clog2(NBITS + 65);
   localparam int TAIL   = NBITS - (NWORDS - 1) * 64;
   localparam logic [WORD_W-1:0] TAIL_MASK =
      (TAIL >= 64) ? {WORD_W{1'b1}} : ((64'd1 << TAIL) - 64'd1);
   localparam logic [AW-1:0] LAST_WORD  = AW'(NWORDS - 1);
   localparam logic [AW:0]   SCAN_LIMIT = (AW + 1)'(NWORDS);

   // Captured request.
   logic [CMD_W-1:0]  op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [WORD_W-1:0] wdata_ff;
   logic [LEN_W-1:0]  len_ff;

   // Scanner state.
   logic [AW:0]       scan_addr_ff;
   logic              pend_ff;
   logic [AW-1:0]     data_word_ff;
   logic [RW-1:0]     carry_ff;
   logic [BW-1:0]     s_ff;
   logic [BW-1:0]     e_ff;
   logic [AW-1:0]     clr_ptr_ff;

   // Result and output registers.
   logic [STATUS_W-1:0] res_status_ff;
   logic [START_W-1:0]  res_start_ff;
   logic [WORD_W-1:0]   res_data_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [START_W-1:0]  rsp_start_ff;
   logic [WORD_W-1:0]   rsp_data_ff;

   logic              idx_ok;
   logic [AW-1:0]     idx_addr;
   logic              len_bad;
   logic [WORD_W-1:0] ram_rdata;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;

   logic [WORD_W-1:0] scan_word;
   logic              zl [7][64];
   logic [5:0]        pl [7][64];
   logic [RW-1:0]     run_v [64];
   logic [63:0]       hit_vec;
   logic [5:0]        hit_pos;
   logic [RW-1:0]     carry_next;
   logic [BW-1:0]     e_bit;
   logic [BW-1:0]     s_bit;

   logic [AW-1:0]     s_word;
   logic [AW-1:0]     e_word;
   logic [5:0]        clr_lo;
   logic [5:0]        clr_hi;
   logic [WORD_W-1:0] clr_mask;
   logic [WORD_W-1:0] clr_word;

   assign idx_ok   = 32'(idx_ff) < 32'(NWORDS);
   assign idx_addr = AW'(idx_ff);
   assign len_bad  = (len_ff == '0) || (32'(len_ff) > 32'(NBITS));

   bea_ram #(
      .WIDTH(WORD_W),
      .DEPTH(NWORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      priority if (cmd.clr_read) begin
         ram_raddr = clr_ptr_ff;
      end else if (cmd.read_word) begin
         ram_raddr = idx_addr;
      end else begin
         ram_raddr = scan_addr_ff[AW-1:0];
      end
   end

   assign ram_we    = (cmd.write_word && idx_ok) || cmd.clr_write;
   assign ram_waddr = cmd.clr_write ? clr_ptr_ff : idx_addr;
   assign ram_wdata = cmd.clr_write ? clr_word : wdata_ff;

   // Blocks at or beyond NBITS in the last word never take part in a run.
   assign scan_word = (data_word_ff == LAST_WORD) ? (ram_rdata & TAIL_MASK) : ram_rdata;

   // Parallel prefix: for each bit, the position of the nearest used bit at or below it.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         zl[0][i] = !scan_word[i];
         pl[0][i] = 6'(i);
      end
      for (int l = 0; l < 6; l++) begin
         for (int i = 0; i < 64; i++) begin
            int j;
            j = (i >= (1 << l)) ? (i - (1 << l)) : i;
            if (!zl[l][i] && (i >= (1 << l))) begin
               zl[l+1][i] = zl[l][j];
               pl[l+1][i] = pl[l][j];
            end else begin
               zl[l+1][i] = zl[l][i];
               pl[l+1][i] = pl[l][i];
            end
         end
      end
   end

   // Length of the free run that ends at each bit, carried in from earlier words.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         if (zl[6][i]) begin
            run_v[i] = RW'(i) - RW'(pl[6][i]);
         end else begin
            run_v[i] = carry_ff + RW'(i + 1);
         end
         hit_vec[i] = scan_word[i] && (run_v[i] >= RW'(len_ff));
      end
   end

   always_comb begin
      hit_pos = '0;
      for (int i = 63; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_pos = 6'(i);
         end
      end
   end

   assign carry_next = zl[6][63] ? RW'(6'd63 - pl[6][63]) : (carry_ff + RW'(64));
   assign e_bit      = {data_word_ff, hit_pos};
   assign s_bit      = e_bit + BW'(1) - BW'(len_ff);

   // Clearing mask for the word under the clear pointer.
   assign s_word   = s_ff[BW-1:6];
   assign e_word   = e_ff[BW-1:6];
   assign clr_lo   = (clr_ptr_ff == s_word) ? s_ff[5:0] : 6'd0;
   assign clr_hi   = (clr_ptr_ff == e_word) ? e_ff[5:0] : 6'd63;
   assign clr_mask = ({WORD_W{1'b1}} << clr_lo) & ({WORD_W{1'b1}} >> (6'd63 - clr_hi));
   assign clr_word = ram_rdata & ~clr_mask;

   assign sts.op       = op_ff;
   assign sts.len_bad  = len_bad;
   assign sts.hit      = pend_ff && (hit_vec != '0);
   assign sts.scan_end = pend_ff && (hit_vec == '0) && (data_word_ff == LAST_WORD);
   assign sts.clr_last = clr_ptr_ff == e_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         pend_ff <= scan_addr_ff < SCAN_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_cmd;
         idx_ff   <= req_word_index;
         wdata_ff <= req_word_data;
         len_ff   <= req_run_length;
      end

      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
         carry_ff     <= '0;
      end else if (cmd.scan_step) begin
         if (scan_addr_ff < SCAN_LIMIT) begin
            scan_addr_ff <= scan_addr_ff + (AW + 1)'(1);
         end
         data_word_ff <= scan_addr_ff[AW-1:0];
         if (pend_ff) begin
            carry_ff <= carry_next;
         end
         if (sts.hit) begin
            s_ff       <= s_bit;
            e_ff       <= e_bit;
            clr_ptr_ff <= s_bit[BW-1:6];
         end
      end

      if (cmd.clr_write && !sts.clr_last) begin
         clr_ptr_ff <= clr_ptr_ff + AW'(1);
      end

      if (cmd.set_res) begin
         unique case (cmd.res_sel)
            RES_ZERO: begin
               res_status_ff <= ST_OK;
               res_start_ff  <= '0;
               res_data_ff   <= '0;
            end
            RES_READ: begin
               res_status_ff <= ST_OK;
               res_start_ff  <= '0;
               res_data_ff   <= idx_ok ? ram_rdata : '0;
            end
            RES_BAD: begin
               res_status_ff <= ST_BAD_COUNT;
               res_start_ff  <= '0;
               res_data_ff   <= '0;
            end
            RES_NOROOM: begin
               res_status_ff <= ST_NO_ROOM;
               res_start_ff  <= '0;
               res_data_ff   <= '0;
            end
            RES_ALLOC: begin
               res_status_ff <= ST_OK;
               res_start_ff  <= START_W'(s_ff);
               res_data_ff   <= '0;
            end
            default: begin
               res_status_ff <= ST_OK;
               res_start_ff  <= '0;
               res_data_ff   <= '0;
            end
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_start_block = rsp_start_ff;
   assign rsp_read_data   = rsp_data_ff;

   // A run found by the scanner never ends before it starts.
   `BEA_ASSERT(a_run_order, clock, reset, (cmd.scan_step && sts.hit) |=> (s_ff <= e_ff), "run end precedes run start")
   // The clear pass never walks past the word holding the end of the run.
   `BEA_ASSERT(a_clr_bound, clock, reset, cmd.clr_write |-> (clr_ptr_ff <= e_word), "clear pointer beyond run end")

endmodule

// ===== rtl/bea_ctrl.sv =====
// Controller state machine of the bitmap extent allocator: request handshake,
// command sequencing and the output register's valid flag.
// Depends on bea_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bea_ctrl import bea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DECODE  = 7'b0000010,
      S_RD_WAIT = 7'b0000100,
      S_SCAN    = 7'b0001000,
      S_CLR_RD  = 7'b0010000,
      S_CLR_WR  = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      cmd.res_sel = RES_ZERO;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_WRITE: begin
                  cmd.write_word = 1'b1;
                  cmd.set_res    = 1'b1;
                  cmd.res_sel    = RES_ZERO;
                  state_in       = S_DONE;
               end
               OP_READ: begin
                  cmd.read_word = 1'b1;
                  state_in      = S_RD_WAIT;
               end
               OP_ALLOC: begin
                  if (sts.len_bad) begin
                     cmd.set_res = 1'b1;
                     cmd.res_sel = RES_BAD;
                     state_in    = S_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  // An unused command changes nothing and answers with zeros.
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_RD_WAIT: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_READ;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            priority if (sts.hit) begin
               state_in = S_CLR_RD;
            end else if (sts.scan_end) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_NOROOM;
               state_in    = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_CLR_RD: begin
            cmd.clr_read = 1'b1;
            state_in     = S_CLR_WR;
         end
         S_CLR_WR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_ALLOC;
               state_in    = S_DONE;
            end else begin
               state_in = S_CLR_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BEA_ASSERT(a_accept_decode, clock, reset, (req_valid && !req_stall) |=> (state_ff == S_DECODE), "accepted request not decoded")
   `BEA_NEVER(a_load_free, clock, reset, cmd.load_rsp && rsp_valid_ff && rsp_stall, "result overwritten while stalled")
   `BEA_ASSERT(a_clear_after_hit, clock, reset, (state_ff == S_CLR_RD && $past(state_ff) == S_SCAN) |-> $past(sts.hit), "clear started without a run")

endmodule

// ===== rtl/bitmap_extent_allocator.sv =====
// Bitmap extent allocator: a first-fit allocator over a free-block bitmap of NBITS bits
// (1 = free) held in a memory of 64-bit words. A write or read request goes through the
// decode step, a read also through the memory's registered read, before its result is set.
// An allocate request scans one bitmap word per cycle through the memory read port and
// then reads back, masks and rewrites each word the run covers in a read state and a
// write state; with no room the scan covers every word. One request is in flight at a
// time; the next is accepted once the previous result sits in the output register.
// The bitmap has no reset; a word must be written before it is read or scanned.
module bitmap_extent_allocator import bea_pkg::*; #(
   parameter int NBITS = 32768
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_word_index,
   input  logic [WORD_W-1:0]   req_word_data,
   input  logic [LEN_W-1:0]    req_run_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0]  rsp_start_block,
   output logic [WORD_W-1:0]   rsp_read_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   bea_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   bea_datapath #(
      .NBITS(NBITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_run_length (req_run_length),
      .rsp_status     (rsp_status),
      .rsp_start_block(rsp_start_block),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the bitmap extent allocator.
// Depends on bea_pkg and the bitmap_extent_allocator top level; it drives requests from a
// queue, predicts every reply from a shadow copy of the bitmap and checks each reply.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bea_pkg::*;

   localparam int NBITS  = 32768;
   localparam int NWORDS = (NBITS + 63) / 64;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] data;
      logic [LEN_W-1:0]  len;
      bit                drain;
   } bitmap_cmd_type;

   typedef struct {
      status_type         status;
      logic [START_W-1:0] start;
      logic [WORD_W-1:0]  rdata;
   } bitmap_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [IDX_W-1:0]    req_word_index = '0;
   logic [WORD_W-1:0]   req_word_data = '0;
   logic [LEN_W-1:0]    req_run_length = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_start_block;
   logic [WORD_W-1:0]   rsp_read_data;

   bitmap_extent_allocator #(.NBITS(NBITS)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_word_index  (req_word_index),
      .req_word_data   (req_word_data),
      .req_run_length  (req_run_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_start_block (rsp_start_block),
      .rsp_read_data   (rsp_read_data)
   );

   bitmap_cmd_type   queued_cmds[$];
   bitmap_reply_type expected_replies[$];
   logic [WORD_W-1:0] shadow_map [NWORDS];

   int unsigned cmds_accepted = 0;
   int unsigned replies_checked = 0;
   int unsigned mismatches = 0;
   int unsigned n_writes = 0, n_reads = 0, n_unused = 0;
   int unsigned n_granted = 0, n_no_room = 0, n_bad_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // First fit over the shadow bitmap; whole words are skipped where that is safe.
   function automatic status_type first_fit_take(input int unsigned len,
                                                 output int unsigned first);
      int unsigned run = 0;
      int unsigned b, s;
      if (len == 0 || len > NBITS) return ST_BAD_COUNT;
      for (int unsigned w = 0; w < NWORDS; w++) begin
         if (shadow_map[w] == '1 && run + 64 < len) begin
            run += 64;
            continue;
         end
         if (shadow_map[w] == '0) begin
            run = 0;
            continue;
         end
         for (int unsigned i = 0; i < 64; i++) begin
            if (shadow_map[w][i]) begin
               run++;
               if (run == len) begin
                  b = w * 64 + i;
                  s = b + 1 - len;
                  for (int unsigned k = s; k <= b; k++) shadow_map[k / 64][k % 64] = 1'b0;
                  first = s;
                  return ST_OK;
               end
            end else begin
               run = 0;
            end
         end
      end
      return ST_NO_ROOM;
   endfunction

   function automatic bitmap_reply_type bitmap_apply(input bitmap_cmd_type c);
      bitmap_reply_type r;
      int unsigned first = 0;
      r.status = ST_OK;
      r.start  = '0;
      r.rdata  = '0;
      case (c.cmd)
         OP_WRITE: begin
            if (c.idx < NWORDS) shadow_map[c.idx] = c.data;
            n_writes++;
         end
         OP_READ: begin
            if (c.idx < NWORDS) r.rdata = shadow_map[c.idx];
            n_reads++;
         end
         OP_ALLOC: begin
            r.status = first_fit_take(c.len, first);
            case (r.status)
               ST_OK: begin
                  r.start = first[START_W-1:0];
                  n_granted++;
               end
               ST_NO_ROOM: n_no_room++;
               default:    n_bad_count++;
            endcase
         end
         default: n_unused++;
      endcase
      return r;
   endfunction

   function automatic void queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                                     input logic [WORD_W-1:0] data, input int unsigned len,
                                     input bit drain = 1'b0);
      bitmap_cmd_type c;
      c.cmd   = cmd;
      c.idx   = idx[IDX_W-1:0];
      c.data  = data;
      c.len   = len[LEN_W-1:0];
      c.drain = drain;
      queued_cmds = {queued_cmds, c};
   endfunction

   // Low words are favoured, since first fit always starts there.
   function automatic int unsigned pick_word();
      return $urandom_range(0, 1) ? $urandom_range(0, NWORDS - 1) : $urandom_range(0, 15);
   endfunction

   // Request driver: bursts of requests separated by random gaps.
   int unsigned burst_left = 4;
   int unsigned gap_left = 0;

   always @(posedge clock) begin : drive_requests
      bit               took;
      bit               valid_next;
      int unsigned      in_flight;
      bitmap_cmd_type   c;
      bitmap_reply_type r;
      if (reset) begin
         req_valid <= 1'b0;
         cmds_accepted <= 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            c.cmd   = req_cmd;
            c.idx   = req_word_index;
            c.data  = req_word_data;
            c.len   = req_run_length;
            c.drain = 1'b0;
            r = bitmap_apply(c);
            expected_replies = {expected_replies, r};
            cmds_accepted <= cmds_accepted + 1;
         end
         in_flight = cmds_accepted + took - replies_checked;
         valid_next = req_valid && !took;
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_cmds.size() > 0 && !(queued_cmds[0].drain && in_flight != 0)) begin
               c = queued_cmds[0];
               queued_cmds.delete(0);
               req_cmd        <= c.cmd;
               req_word_index <= c.idx;
               req_word_data  <= c.data;
               req_run_length <= c.len;
               valid_next = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) == 0) begin
                  burst_left = 40;
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 6);
                  gap_left = $urandom_range(1, 8);
               end
            end
         end
         req_valid <= valid_next;
      end
   end

   // Reply monitor, with a stall pattern whose mode is picked at random whenever stall_tick wraps.
   int unsigned stall_tick = 0;
   int unsigned stall_mode = 0;

   always @(posedge clock) begin : check_replies
      bitmap_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         replies_checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_checked >= cmds_accepted) begin
               report_mismatch("reply arrived with no request outstanding");
            end else begin
               want = expected_replies[replies_checked];
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("request %0d: status %0d, expected %0d",
                                            replies_checked, rsp_status, want.status));
               if (rsp_start_block !== want.start)
                  report_mismatch($sformatf("request %0d: start block %0d, expected %0d",
                                            replies_checked, rsp_start_block, want.start));
               if (rsp_read_data !== want.rdata)
                  report_mismatch($sformatf("request %0d: read data %h, expected %h",
                                            replies_checked, rsp_read_data, want.rdata));
               replies_checked <= replies_checked + 1;
            end
         end
         if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
         stall_tick = (stall_tick + 1) % 200;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   initial begin
      int unsigned pick, lo, hi, len;
      logic [WORD_W-1:0] word;

      // Every word must hold a known value before any read or allocation.
      for (int unsigned w = 0; w < NWORDS; w++) queue_cmd(OP_WRITE, w, '1, 0);

      queue_cmd(OP_READ, 0, '0, 0);
      queue_cmd(OP_READ, NWORDS - 1, '1, 16'hFFFF);
      queue_cmd(OP_ALLOC, 0, '0, 0);
      queue_cmd(OP_ALLOC, 0, '0, NBITS + 1);
      queue_cmd(OP_ALLOC, 0, '0, 16'hFFFF);
      // The whole map in one run, sent only after everything before it has replied.
      queue_cmd(OP_ALLOC, 0, '0, NBITS, 1'b1);
      queue_cmd(OP_ALLOC, 0, '0, 1);
      queue_cmd(OP_READ, 300, '0, 0);
      queue_cmd(CMD_UNUSED, 7, '1, 5);
      queue_cmd(OP_WRITE, NWORDS - 1, 64'h8000_0000_0000_0000, 0);
      queue_cmd(OP_ALLOC, 0, '0, 1);
      queue_cmd(OP_ALLOC, 0, '0, 1);
      queue_cmd(OP_READ, NWORDS - 1, '0, 0);
      // Used blocks at 1 and 3 must restart the run, so it lands on blocks 4 to 6.
      queue_cmd(OP_WRITE, 0, 64'h0000_0000_0000_00F5, 0);
      queue_cmd(OP_ALLOC, 0, '0, 3);
      queue_cmd(OP_READ, 0, '0, 0);
      queue_cmd(OP_WRITE, 1, '1, 0);
      queue_cmd(OP_WRITE, 2, '1, 0);
      queue_cmd(OP_ALLOC, 0, '0, 100);
      queue_cmd(OP_READ, 1, '0, 0);
      queue_cmd(OP_READ, 2, '0, 0);
      queue_cmd(OP_READ, 0, '0, 0);

      for (int unsigned n = 0; n < 466; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            case ($urandom_range(0, 9))
               0, 1, 2: word = '1;
               3, 4, 5: word = {$urandom, $urandom};
               6:       word = '0;
               default: begin
                  lo = $urandom_range(0, 63);
                  hi = $urandom_range(lo, 63);
                  word = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (63 - hi));
               end
            endcase
            queue_cmd(OP_WRITE, pick_word(), word, $urandom_range(0, 65535));
         end else if (pick < 55) begin
            queue_cmd(OP_READ, pick_word(), {$urandom, $urandom}, $urandom_range(0, 65535));
         end else if (pick < 95) begin
            lo = $urandom_range(0, 99);
            if (lo < 60)      len = $urandom_range(1, 16);
            else if (lo < 80) len = $urandom_range(17, 200);
            else if (lo < 92) len = $urandom_range(201, 4096);
            else if (lo < 95) len = $urandom_range(4097, NBITS);
            else if (lo < 97) len = 0;
            else              len = $urandom_range(NBITS + 1, 65535);
            queue_cmd(OP_ALLOC, $urandom_range(0, NWORDS - 1), {$urandom, $urandom}, len,
                      $urandom_range(0, 99) < 3);
         end else begin
            queue_cmd(CMD_UNUSED, $urandom_range(0, NWORDS - 1), {$urandom, $urandom},
                      $urandom_range(0, 65535));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (queued_cmds.size() != 0 || req_valid || replies_checked != cmds_accepted)
         @(posedge clock);
      // A further wait after every accepted request has replied, before the final check.
      repeat (1200) @(posedge clock);
      if (replies_checked != cmds_accepted)
         report_mismatch($sformatf("%0d replies never arrived", cmds_accepted - replies_checked));

      $display("Run covered %0d requests: %0d writes, %0d reads, %0d with the unused command.",
               cmds_accepted, n_writes, n_reads, n_unused);
      $display("Allocations: %0d granted, %0d found no room, %0d rejected for their count.",
               n_granted, n_no_room, n_bad_count);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bea_pkg.sv
rtl/bea_ram.sv
rtl/bea_datapath.sv
rtl/bea_ctrl.sv
rtl/bitmap_extent_allocator.sv
tb/sv/testbench.sv
